FILE: rtl/sdtq_pkg.sv
// shared types and constants for the sorted deadline timer queue
package sdtq_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int TIME_W        = 48;
  localparam int DELAY_W       = 32;
  localparam int FUZZ_W        = 20;
  localparam logic [FUZZ_W-1:0] FUZZ_RESET = 20'd500;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT_OUT,
    ST_SCAN,
    ST_SHIFT_IN,
    ST_CHK_HEAD,
    ST_CHK_EMIT,
    ST_CHK_FINAL,
    ST_OUT_WAIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture input transaction
    logic find_start;  // begin search for slot in list
    logic find_step;   // advance search index
    logic rm_step;     // close gap at search index
    logic rm_done;     // finish removal
    logic scan_start;  // begin insert position scan
    logic scan_step;   // advance scan index
    logic ins_step;    // open gap from top
    logic ins_done;    // place the new entry
    logic head_remove; // remove list head (expiry)
    logic out_expiry;  // load output register with expiry
    logic out_final;   // load output register with final report
    logic out_clear;   // output taken
    logic fired_clr;   // clear fired flag
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic set_ok;      // set with nonzero delay and valid slot
    logic id_ok;       // slot number in range
    logic armed;       // addressed slot is armed
    logic found;       // search index holds slot
    logic find_end;    // search index reached count
    logic rm_end;      // gap closed to end of list
    logic scan_stop;   // insert position found
    logic ins_end;     // gap reached insert position
    logic full;        // list full
    logic empty;       // list empty
    logic head_due;    // head deadline within limit
    logic out_valid;   // output register holds a result
  } dp_stat_t;

endpackage

FILE: rtl/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
// set and cancel walk the ordered list and shift entries to close or open a gap
// check: each expiry passes the head compare, gap close and settle states, then the
// final report follows; both wait while the receiver stalls
// throughput: one transaction at a time; the ordered list walk sets the rate
// reset: synchronous active-high rst clears count, flags, output and fuzz to 500
// deadline and order storage are not cleared; only armed entries are read
module sorted_deadline_timer_queue #(
  parameter int TIMER_SLOTS = sdtq_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [3:0]                    timer_id,
  input  logic [sdtq_pkg::DELAY_W-1:0]  delay_ticks,
  input  logic [sdtq_pkg::TIME_W-1:0]   now_time,
  input  logic                          cfg_we,
  input  logic [sdtq_pkg::FUZZ_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [3:0]                    expired_id,
  output logic [sdtq_pkg::TIME_W-1:0]   wait_time,
  output logic                          fired_any,
  output logic                          last
);
  import sdtq_pkg::*;

  dp_cmd_t  dc;
  dp_stat_t st;

  // controller sequences list walks and result emission
  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd_t'(command)),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .dc        (dc)
  );

  // datapath holds the ordered list and the output register
  sdtq_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .timer_id    (timer_id),
    .delay_ticks (delay_ticks),
    .now_time    (now_time),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .dc          (dc),
    .st          (st),
    .result_kind (result_kind),
    .expired_id  (expired_id),
    .wait_time   (wait_time),
    .fired_any   (fired_any),
    .last        (last),
    .out_valid   (out_valid)
  );

endmodule

FILE: rtl/sdtq_ctrl.sv
// controller state machine for the sorted deadline timer queue
module sdtq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sdtq_pkg::cmd_t    cmd,
  input  logic              out_ready,
  input  sdtq_pkg::dp_stat_t st,
  output logic              in_ready,
  output sdtq_pkg::dp_cmd_t dc
);
  import sdtq_pkg::*;

  state_t state, state_next;
  cmd_t   cur, cur_next;
  logic   set_mode, set_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= CMD_NONE;
      set_mode <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      set_mode <= set_mode_next;
    end
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    set_mode_next = set_mode;
    dc            = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dc.load   = 1'b1;
          cur_next  = cmd;
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        // first cycle after load: decide
        unique case (cur)
          CMD_SET: begin
            if (!st.set_ok) begin
              state_next = ST_IDLE;
            end else if (st.armed) begin
              set_mode_next = 1'b1;
              dc.find_start = 1'b1;
              state_next    = ST_SHIFT_OUT;
            end else begin
              dc.scan_start = 1'b1;
              state_next    = ST_SCAN;
            end
          end
          CMD_CANCEL: begin
            if (st.id_ok && st.armed) begin
              set_mode_next = 1'b0;
              dc.find_start = 1'b1;
              state_next    = ST_SHIFT_OUT;
            end else begin
              state_next = ST_IDLE;
            end
          end
          CMD_CHECK: begin
            dc.fired_clr = 1'b1;
            state_next   = ST_CHK_HEAD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SHIFT_OUT: begin
        // search for slot, then close the gap
        if (st.found) begin
          if (st.rm_end) begin
            dc.rm_done = 1'b1;
            if (set_mode) begin
              state_next = ST_SCAN;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            dc.rm_step = 1'b1;
          end
        end else if (st.find_end) begin
          dc.rm_done = 1'b1;
          state_next = set_mode ? ST_SCAN : ST_IDLE;
        end else begin
          dc.find_step = 1'b1;
        end
        if (state_next == ST_SCAN) begin
          dc.scan_start = 1'b1;
        end
      end
      ST_SCAN: begin
        if (st.full) begin
          state_next = ST_IDLE;
        end else if (st.scan_stop) begin
          state_next = ST_SHIFT_IN;
        end else begin
          dc.scan_step = 1'b1;
        end
      end
      ST_SHIFT_IN: begin
        if (st.ins_end) begin
          dc.ins_done = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          dc.ins_step = 1'b1;
        end
      end
      ST_CHK_HEAD: begin
        if (!st.out_valid) begin
          if (!st.empty && st.head_due) begin
            dc.out_expiry  = 1'b1;
            dc.head_remove = 1'b1;
            dc.find_start  = 1'b1;
            state_next     = ST_CHK_EMIT;
          end else begin
            dc.out_final = 1'b1;
            state_next   = ST_CHK_FINAL;
          end
        end
      end
      ST_CHK_EMIT: begin
        // head removal: close the gap at index 0
        if (st.rm_end) begin
          dc.rm_done = 1'b1;
          state_next = ST_OUT_WAIT;
        end else begin
          dc.rm_step = 1'b1;
        end
      end
      ST_OUT_WAIT: begin
        state_next = ST_CHK_HEAD;
      end
      ST_CHK_FINAL: begin
        if (!st.out_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (st.out_valid && out_ready) begin
      dc.out_clear = 1'b1;
    end
  end

endmodule

FILE: rtl/sdtq_dp.sv
// datapath: deadline store, ordered list, count, flags and output register
module sdtq_dp #(
  parameter int TIMER_SLOTS = sdtq_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    command,
  input  logic [3:0]                    timer_id,
  input  logic [sdtq_pkg::DELAY_W-1:0]  delay_ticks,
  input  logic [sdtq_pkg::TIME_W-1:0]   now_time,
  input  logic                          cfg_we,
  input  logic [sdtq_pkg::FUZZ_W-1:0]   cfg_wdata,
  input  sdtq_pkg::dp_cmd_t             dc,
  output sdtq_pkg::dp_stat_t            st,
  output logic                          result_kind,
  output logic [3:0]                    expired_id,
  output logic [sdtq_pkg::TIME_W-1:0]   wait_time,
  output logic                          fired_any,
  output logic                          last,
  output logic                          out_valid
);
  import sdtq_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TIMER_SLOTS);

  logic [TIME_W-1:0]  deadline_store [TIMER_SLOTS];
  logic [IW-1:0]      order_list     [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] armed_flags;
  logic [CW-1:0]      armed_count;
  logic [FUZZ_W-1:0]  fuzz_window;

  logic [IW-1:0]      cid;
  logic               cid_ok;
  logic [TIME_W-1:0]  cdl;
  logic [TIME_W-1:0]  cnow;
  logic               cdelay_nz;
  logic [TIME_W:0]    limit;
  logic [CW-1:0]      idx;   // search / scan index
  logic [CW-1:0]      top;   // insert gap index
  logic               fired;

  logic [TIME_W:0]    sum;
  logic [IW-1:0]      at_idx;
  logic [IW-1:0]      head;
  logic [TIME_W-1:0]  head_dl;

  assign sum  = {1'b0, now_time} + {{(TIME_W-DELAY_W+1){1'b0}}, delay_ticks};
  assign head = order_list[0];
  assign head_dl = deadline_store[head];
  assign at_idx = (idx < FULL_CNT) ? order_list[idx[IW-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuzz_window <= FUZZ_RESET;
    end else if (cfg_we) begin
      fuzz_window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (dc.load) begin
      cid       <= IW'(timer_id);
      cid_ok    <= ({28'd0, timer_id} < 32'(TIMER_SLOTS));
      cdl       <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      cnow      <= now_time;
      cdelay_nz <= (delay_ticks != '0) && (command == CMD_SET);
      limit     <= {1'b0, now_time} + {{(TIME_W-FUZZ_W+1){1'b0}}, fuzz_window};
    end
  end

  always_ff @(posedge clk) begin
    if (dc.find_start || dc.scan_start) begin
      idx <= '0;
    end else if (dc.find_step || dc.rm_step || dc.scan_step) begin
      idx <= idx + 1'b1;
    end
    if (dc.scan_start) begin
      top <= armed_count - CW'(dc.rm_done);
    end else if (dc.ins_step) begin
      top <= top - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dc.rm_step) begin
      order_list[idx[IW-1:0]] <= order_list[idx[IW-1:0] + 1'b1];
    end
    if (dc.ins_step) begin
      order_list[top[IW-1:0]] <= order_list[top[IW-1:0] - 1'b1];
    end
    if (dc.ins_done) begin
      order_list[top[IW-1:0]] <= cid;
      deadline_store[cid]     <= cdl;
    end
  end

  // remove target: head on expiry, else held slot
  logic [IW-1:0] rm_id;
  logic          rm_head;
  logic          found_hold;
  always_ff @(posedge clk) begin
    if (rst) begin
      rm_head <= 1'b0;
    end else if (dc.head_remove) begin
      rm_head <= 1'b1;
      rm_id   <= head;
    end else if (dc.rm_done) begin
      rm_head <= 1'b0;
    end
    if (dc.load) begin
      rm_id <= IW'(timer_id);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flags <= '0;
      armed_count <= '0;
    end else begin
      if (dc.rm_done) begin
        armed_flags[rm_id] <= 1'b0;
        armed_count        <= armed_count - 1'b1;
      end
      if (dc.ins_done) begin
        armed_flags[cid] <= 1'b1;
        armed_count      <= armed_count + 1'b1;
      end
    end
  end

  // close gap ends when idx+1 reaches count
  assign st.set_ok    = cdelay_nz && cid_ok;
  assign st.id_ok     = cid_ok;
  assign st.armed     = cid_ok && armed_flags[cid];
  assign st.found     = rm_head || (idx < armed_count && at_idx == rm_id)
                        || found_hold;
  assign st.find_end  = (idx >= armed_count);
  assign st.rm_end    = ((idx + 1'b1) >= armed_count);
  assign st.scan_stop = (idx >= armed_count) || (deadline_store[at_idx] > cdl);
  assign st.ins_end   = (top == idx);
  assign st.full      = (armed_count >= FULL_CNT);
  assign st.empty     = (armed_count == '0);
  assign st.head_due  = ({1'b0, head_dl} <= limit);
  assign st.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst || dc.find_start || dc.rm_done) begin
      found_hold <= 1'b0;
    end else if (st.found) begin
      found_hold <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fired     <= 1'b0;
    end else begin
      if (dc.fired_clr) begin
        fired <= 1'b0;
      end
      if (dc.out_clear) begin
        out_valid <= 1'b0;
      end
      if (dc.out_expiry) begin
        out_valid   <= 1'b1;
        fired       <= 1'b1;
        result_kind <= 1'b0;
        expired_id  <= 4'(head);
        wait_time   <= '0;
        fired_any   <= 1'b1;
        last        <= 1'b0;
      end
      if (dc.out_final) begin
        out_valid   <= 1'b1;
        result_kind <= 1'b1;
        expired_id  <= '0;
        wait_time   <= st.empty ? '0 : head_dl - cnow;
        fired_any   <= fired;
        last        <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sdtq_checker.sv
// port level checks for the sorted deadline timer queue
module sdtq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic       last,
  input logic       fired_any,
  input logic [47:0] wait_time
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wait_time))
    else $error("result dropped while stalled");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == result_kind))
    else $error("last flag mismatches result kind");
  a_expiry_fired: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> fired_any && wait_time == 48'd0)
    else $error("expiry result fields wrong");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("transaction accepted while result pending");
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
  .last(last), .fired_any(fired_any), .wait_time(wait_time)
);

FILE: tb/tb.sv
// testbench for the sorted deadline timer queue: scoreboard class, drivers and checks
`timescale 1ns / 100ps

module tb;
  import sdtq_pkg::*;

  localparam int N_SLOTS    = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [47:0] MAX_TIME = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [3:0]  id;
    logic [47:0] wait_t;
    logic        fired;
    logic        lst;
  } timer_result_t;

  // predicts the list contents and holds the expected results
  class timer_scoreboard;
    logic [47:0]   deadline[N_SLOTS];
    logic [3:0]    order[N_SLOTS];
    int            count;
    bit            armed[N_SLOTS];
    logic [19:0]   fuzz;
    timer_result_t pending[$];
    int            mismatches;
    int            checked;

    function void clear_all();
      count = 0;
      fuzz = FUZZ_RESET;
      foreach (armed[i]) armed[i] = 0;
    endfunction

    function void unlink(int slot);
      int pos;
      if (!armed[slot]) return;
      pos = 0;
      while (order[pos] != slot) pos++;
      for (int j = pos; j + 1 < count; j++) order[j] = order[j+1];
      count--;
      armed[slot] = 0;
    endfunction

    function void link(int slot, logic [47:0] dl);
      int pos;
      pos = 0;
      while (pos < count && deadline[order[pos]] <= dl) pos++;
      for (int j = count; j > pos; j--) order[j] = order[j-1];
      order[pos] = slot;
      count++;
      deadline[slot] = dl;
      armed[slot] = 1;
    endfunction

    function void note_command(cmd_t cmd, logic [3:0] id, logic [31:0] dly, logic [47:0] now);
      logic [48:0]   sum;
      logic [48:0]   lim;
      logic [47:0]   wt;
      bit            fired;
      timer_result_t r;
      case (cmd)
        CMD_SET: begin
          if (dly != 0) begin
            unlink(id);
            sum = {1'b0, now} + dly;
            link(id, sum[48] ? MAX_TIME : sum[47:0]);
          end
        end
        CMD_CANCEL: begin
          unlink(id);
        end
        CMD_CHECK: begin
          lim = {1'b0, now} + fuzz;
          wt = 0;
          fired = 0;
          while (count > 0) begin
            if ({1'b0, deadline[order[0]]} > lim) begin
              wt = deadline[order[0]] - now;
              break;
            end
            r = '{kind: 1'b0, id: order[0], wait_t: 48'd0, fired: 1'b1, lst: 1'b0};
            pending.push_back(r);
            unlink(order[0]);
            fired = 1;
          end
          r = '{kind: 1'b1, id: 4'd0, wait_t: wt, fired: fired, lst: 1'b1};
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = CMD_NONE;
  logic [3:0]  timer_id = 0;
  logic [31:0] delay_ticks = 0;
  logic [47:0] now_time = 0;
  logic        cfg_we = 0;
  logic [19:0] cfg_wdata = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        result_kind;
  logic [3:0]  expired_id;
  logic [47:0] wait_time;
  logic        fired_any;
  logic        last;

  timer_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  idle_cycles = 0;
  int  sent = 0;
  logic [47:0] clock_now = 48'd1000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  sorted_deadline_timer_queue i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .timer_id(timer_id), .delay_ticks(delay_ticks), .now_time(now_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .expired_id(expired_id), .wait_time(wait_time),
    .fired_any(fired_any), .last(last)
  );

  // receiver: random stalls, and a long hold-off while hold_off is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // sample transactions at each edge; the watchdog counts edges with no transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{kind: result_kind, id: expired_id, wait_t: wait_time,
                          fired: fired_any, lst: last});
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one command and hold it until accepted; gaps before it by send_idle_pct
  // valid stays up after acceptance until the next gap or drain
  task automatic send_cmd(cmd_t cmd, logic [3:0] id, logic [31:0] dly, logic [47:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid    <= 1;
    command     <= cmd;
    timer_id    <= id;
    delay_ticks <= dly;
    now_time    <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, id, dly, now);
    sent++;
  endtask

  // wait for all expected results, then let any set or cancel finish its list walk
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * N_SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_fuzz(logic [19:0] val);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.fuzz = val;
  endtask

  // mostly sets around the running clock, with cancels, checks and odd items
  task automatic random_cmd();
    int    pick;
    logic [31:0] dly;
    pick = $urandom_range(99);
    clock_now = clock_now + $urandom_range(800);
    case ($urandom_range(9))
      0:       dly = $urandom();
      1:       dly = 0;
      default: dly = $urandom_range(3000, 1);
    endcase
    if (pick < 50)      send_cmd(CMD_SET, 4'($urandom_range(15)), dly, clock_now);
    else if (pick < 65) send_cmd(CMD_CANCEL, 4'($urandom_range(15)), $urandom(), clock_now);
    else if (pick < 95) send_cmd(CMD_CHECK, 4'($urandom_range(15)), $urandom(), clock_now);
    else if (pick < 98) send_cmd(CMD_NONE, 4'($urandom_range(15)), $urandom(), clock_now);
    else send_cmd(CMD_CHECK, 4'($urandom_range(15)), $urandom(),
                  48'({$urandom(), $urandom()}));
  endtask

  initial begin
    sb.clear_all();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty check, zero delay, idle cancel, ties, saturation, unused code
    send_cmd(CMD_CHECK, 4'd0, 32'd0, 48'd0);
    send_cmd(CMD_SET, 4'd3, 32'd0, 48'd100);
    send_cmd(CMD_CANCEL, 4'd5, 32'd0, 48'd100);
    send_cmd(CMD_SET, 4'd1, 32'd1000, 48'd0);
    send_cmd(CMD_SET, 4'd2, 32'd1000, 48'd0);
    send_cmd(CMD_SET, 4'd15, 32'hFFFF_FFFF, MAX_TIME);
    send_cmd(CMD_SET, 4'd0, 32'd10, 48'd0);
    send_cmd(CMD_SET, 4'd0, 32'd5000, 48'd0);
    send_cmd(CMD_CHECK, 4'd0, 32'd0, 48'd0);
    send_cmd(CMD_NONE, 4'd7, 32'hFFFF_FFFF, MAX_TIME);
    send_cmd(CMD_CHECK, 4'hF, 32'hFFFF_FFFF, 48'd600);
    send_cmd(CMD_CANCEL, 4'd0, 32'd0, 48'd0);
    send_cmd(CMD_CHECK, 4'd0, 32'd0, 48'h7FFF_FFFF_FFFF);
    send_cmd(CMD_CHECK, 4'd0, 32'd0, MAX_TIME);
    for (int s = 0; s < N_SLOTS; s++) send_cmd(CMD_SET, s[3:0], 32'd50 + s % 3, 48'd0);
    write_fuzz(20'd0);
    send_cmd(CMD_CHECK, 4'd0, 32'd0, 48'd51);
    write_fuzz(20'hFFFFF);
    send_cmd(CMD_CHECK, 4'd0, 32'd0, 48'd0);
    clock_now = 48'd1000;

    // random phases with varying idling and fuzz settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_fuzz(FUZZ_RESET); end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  write_fuzz(20'd0); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; write_fuzz(20'hFFFFF); end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; write_fuzz(20'd300); end
      endcase
      for (int k = 0; k < 38; k++) random_cmd();
    end

    // long receiver hold-off while checks keep coming, so the input stalls
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 12; k++) begin
        send_cmd(CMD_SET, k[3:0], 32'd1, clock_now);
        send_cmd(CMD_CHECK, 4'd0, 32'd0, clock_now + 5);
      end
    join

    drain();
    $display("sent %0d commands, checked %0d results over 4 idling phases and 4 fuzz values",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/sdtq_pkg.sv
rtl/sdtq_ctrl.sv
rtl/sdtq_dp.sv
rtl/sorted_deadline_timer_queue.sv
rtl/sdtq_checker.sv
tb/tb.sv
